FILE: hw/rtl/ttfs_pkg.sv
// ttfs_pkg: shared widths, codes and types for the tap tempo footswitch controller
// no dependencies; imported by tap_tempo_footswitch_fsm
`default_nettype none

package ttfs_pkg;

    // timestamp arithmetic width, differences wrap modulo 2^TIME_WIDTH
    localparam int TIME_WIDTH = 32;
    localparam int CFG_WIDTH  = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [CFG_WIDTH-1:0]  cfg_t;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH   = 2'd3;

    // config reset values
    localparam cfg_t DEBOUNCE_RST = 16'd50;
    localparam cfg_t LONG_RST     = 16'd1000;
    localparam cfg_t MAX_INT_RST  = 16'd3000;
    localparam cfg_t FINISH_RST   = 16'd3000;

    // item function codes
    localparam logic [1:0] FUNC_POLL    = 2'd0;
    localparam logic [1:0] FUNC_EDGE    = 2'd1;
    localparam logic [1:0] FUNC_TEMPO_B = 2'd2;
    localparam logic [1:0] FUNC_READ    = 2'd3;

    // event codes beyond the mode codes
    localparam logic [2:0] EV_TOGGLE = 3'd5;
    localparam logic [2:0] EV_DONE   = 3'd6;
    localparam logic [2:0] EV_DONEB  = 3'd7;

endpackage

`default_nettype wire

FILE: hw/rtl/tap_tempo_footswitch_fsm.sv
// tap_tempo_footswitch_fsm: footswitch timing controller with tap tempo capture
// depends on ttfs_pkg
`default_nettype none

// Footswitch controller driven by millisecond timestamps. Each input item is a
// poll, a press edge, a tempo B start or a tempo read, and each item produces
// exactly one result item: an event code (the mode, or toggle / done /
// done_b), the current tempo and the ready flag. All time differences wrap
// modulo 2^TIME_WIDTH. Throughput is one item per clock while the output is not
// stalled; each item is held in the input register, then the mode update and
// all gap compares (a handful of 32 bit subtract-compares) resolve in one pass
// and load the state and result registers together as the item moves on. The
// result register is decoupled from the input side, so a new item is taken
// while a finished result still waits; in_stall is only raised when both
// registers hold items and the output is stalled.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data) and is
// expected only while the block is idle. No memories and no clearing pass.
module tap_tempo_footswitch_fsm
    import ttfs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config write port
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire cfg_t                 cfg_data,
    // input item channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           func,
    input  wire time_t                time_ms,
    input  wire logic                 pin_low,
    // result item channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                event_res,
    output logic [15:0]               tempo_ms,
    output logic                      tempo_ready
);

    typedef enum logic [2:0] {
        M_OPEN  = 3'd0,
        M_PRESS = 3'd1,
        M_TAP   = 3'd2,
        M_HOLD  = 3'd3,
        M_HOLDB = 3'd4
    } mode_t;

    // config registers
    cfg_t debounce_reg;
    cfg_t long_reg;
    cfg_t max_int_reg;
    cfg_t finish_reg;

    // input register stage
    logic       s1_valid_reg;
    logic [1:0] s1_func_reg;
    time_t      s1_time_reg;
    logic       s1_pin_reg;

    // controller state
    mode_t       mode_reg, mode_next;
    logic        pend_reg, pend_next;
    time_t       edge_time_reg, edge_time_next;
    time_t       mark_time_reg, mark_time_next;
    logic [15:0] tempo_reg, tempo_next;
    logic        ready_reg, ready_next;
    logic [2:0]  ev_next;

    // result register
    logic        out_valid_reg;
    logic [2:0]  ev_reg;
    logic [15:0] tempo_out_reg;
    logic        ready_out_reg;

    logic  out_free;
    logic  s1_fire;
    time_t now_gap;
    time_t edge_gap;
    time_t deb_w, long_w, max_w, fin_w;

    // handshake: result reg frees when empty or taken, input reg moves on then
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            long_reg     <= LONG_RST;
            max_int_reg  <= MAX_INT_RST;
            finish_reg   <= FINISH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_LONG:     long_reg     <= cfg_data;
                CFG_MAX_INT:  max_int_reg  <= cfg_data;
                CFG_FINISH:   finish_reg   <= cfg_data;
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_func_reg <= func;
            s1_time_reg <= time_ms;
            s1_pin_reg  <= pin_low;
        end
    end

    // wrapped gaps against the last mark, config widened to time width
    assign now_gap  = s1_time_reg - mark_time_reg;
    assign edge_gap = edge_time_reg - mark_time_reg;
    assign deb_w    = time_t'(debounce_reg);
    assign long_w   = time_t'(long_reg);
    assign max_w    = time_t'(max_int_reg);
    assign fin_w    = time_t'(finish_reg);

    // one pass of the controller for the item in the input register
    always_comb
    begin
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        edge_time_next = edge_time_reg;
        mark_time_next = mark_time_reg;
        tempo_next     = tempo_reg;
        ready_next     = ready_reg;
        ev_next        = 3'(M_OPEN);
        case (s1_func_reg)
            FUNC_POLL:
            begin
                case (mode_reg)
                    M_PRESS:
                    begin
                        if (s1_pin_reg)
                        begin
                            // held long enough: enter tap mode, restart tempo
                            if (now_gap >= long_w)
                            begin
                                mode_next      = M_TAP;
                                mark_time_next = s1_time_reg;
                                tempo_next     = 16'd0;
                            end
                        end
                        else if (now_gap > deb_w)
                        begin
                            // short press released: toggle
                            mode_next      = M_OPEN;
                            mark_time_next = s1_time_reg;
                            pend_next      = 1'b0;
                            ready_next     = 1'b0;
                        end
                    end
                    M_TAP:
                    begin
                        mode_next      = M_HOLD;
                        mark_time_next = s1_time_reg;
                    end
                    M_HOLD, M_HOLDB:
                    begin
                        if (pend_reg)
                        begin
                            // consume the tap, keep it if the gap is in bounds
                            pend_next = 1'b0;
                            if (edge_gap >= deb_w && edge_gap < max_w)
                            begin
                                mark_time_next = edge_time_reg;
                                tempo_next     = edge_gap[15:0];
                                ready_next     = 1'b1;
                            end
                        end
                        else if (now_gap > fin_w && tempo_reg != 16'd0)
                        begin
                            // idle timeout with a tempo: capture done
                            mode_next      = M_OPEN;
                            mark_time_next = s1_time_reg;
                            pend_next      = 1'b0;
                            ready_next     = 1'b0;
                        end
                    end
                    default:
                    begin
                        // open (and any stray code): take a debounced press
                        mode_next = M_OPEN;
                        if (pend_reg)
                        begin
                            pend_next = 1'b0;
                            if (edge_gap >= deb_w)
                            begin
                                mark_time_next = edge_time_reg;
                                mode_next      = M_PRESS;
                            end
                        end
                    end
                endcase
            end
            FUNC_EDGE:
            begin
                // latch the edge only while the pin reads low
                if (s1_pin_reg)
                begin
                    pend_next      = 1'b1;
                    edge_time_next = s1_time_reg;
                end
            end
            FUNC_TEMPO_B:
            begin
                mode_next      = M_HOLDB;
                edge_time_next = s1_time_reg;
                mark_time_next = s1_time_reg;
                ready_next     = 1'b0;
            end
            default:
            begin
                // tempo read clears ready
                ready_next = 1'b0;
            end
        endcase

        // event: special codes on toggle and done, else the new mode
        ev_next = 3'(mode_next);
        if (s1_func_reg == FUNC_POLL && mode_next == M_OPEN)
        begin
            if (mode_reg == M_PRESS)
            begin
                ev_next = EV_TOGGLE;
            end
            else if (mode_reg == M_HOLD)
            begin
                ev_next = EV_DONE;
            end
            else if (mode_reg == M_HOLDB)
            begin
                ev_next = EV_DONEB;
            end
        end
    end

    // state and result registers load together when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_OPEN;
            pend_reg      <= 1'b0;
            edge_time_reg <= '0;
            mark_time_reg <= '0;
            tempo_reg     <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                mode_reg      <= mode_next;
                pend_reg      <= pend_next;
                edge_time_reg <= edge_time_next;
                mark_time_reg <= mark_time_next;
                tempo_reg     <= tempo_next;
                ready_reg     <= ready_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            ev_reg        <= ev_next;
            tempo_out_reg <= tempo_next;
            ready_out_reg <= ready_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign tempo_ms    = tempo_out_reg;
    assign tempo_ready = ready_out_reg;

    // a finishing event leaves the controller open with ready cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (ev_reg == EV_TOGGLE || ev_reg == EV_DONE || ev_reg == EV_DONEB))
        |-> (mode_reg == M_OPEN && !ready_reg))
        else $error("finish event without return to open");

    // stall only with an item waiting in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    // an item that leaves the input register shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("item lost between input and result register");

    // a tempo read always reports ready cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_func_reg == FUNC_READ) |=> !tempo_ready)
        else $error("tempo read did not clear ready");

endmodule

`default_nettype wire
